// ===== rtl/delimited_frame_xor_check_parser_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the delimited frame parser
// Concurrent checks clocked on clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef DELIMITED_FRAME_XOR_CHECK_PARSER_UNIT_ASSERT_SVH
`define DELIMITED_FRAME_XOR_CHECK_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTH
`define DFXC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define DFXC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DFXC_ASSERT_SAME(label, ante, cons, msg)
`define DFXC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/dfxc_pkg.sv =====
// ---------------------------------------------------------------------------
// Delimited frame parser package
// Result kinds, register indexes, reset values and the result record.
// ---------------------------------------------------------------------------
package dfxc_pkg;

	localparam logic [1:0] KIND_BODY      = 2'd0;
	localparam logic [1:0] KIND_ACCEPTED  = 2'd1;
	localparam logic [1:0] KIND_BAD_END   = 2'd2;
	localparam logic [1:0] KIND_BAD_CHECK = 2'd3;

	localparam logic [0:0] REG_START_MARKER = 1'd0;
	localparam logic [0:0] REG_END_MARKER   = 1'd1;

	localparam logic [7:0] START_MARKER_RST = 8'hF0;
	localparam logic [7:0] END_MARKER_RST   = 8'h0F;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [7:0] frame_serial;
		logic [7:0] frame_command;
		logic [2:0] command_class;
		logic [7:0] body_length;
		logic       last;
	} result_t;

endpackage

// ===== rtl/delimited_frame_xor_check_parser_unit.sv =====
// ---------------------------------------------------------------------------
// Delimited frame parser with XOR check
// Hunts for the start marker, passes body bytes, checks end marker and XOR.
// ---------------------------------------------------------------------------
//  channel | signals                         | beat
//  in      | in_valid, in_ready, byte_in     | one link byte
//  out     | out_valid, out_ready, fields    | body byte or frame verdict
//  cfg     | cfg_write, cfg_index, cfg_data  | marker register write
//
// One byte per cycle unless a held result stalls input; a result shows in the cycle after its byte is taken.
// The frame phase register steps once per accepted byte.
// A held result stalls input only when out_ready is low.
// Reset returns to the hunt phase with markers 0xF0 and 0x0F.
// ---------------------------------------------------------------------------
`include "delimited_frame_xor_check_parser_unit_assert.svh"

module delimited_frame_xor_check_parser_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic [7:0] frame_serial,
	output logic [7:0] frame_command,
	output logic [2:0] command_class,
	output logic [7:0] body_length,
	output logic       last
);

	logic [7:0]        start_marker_q;
	logic [7:0]        end_marker_q;
	logic              step;
	logic              res_valid;
	dfxc_pkg::result_t res;
	dfxc_pkg::result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= dfxc_pkg::START_MARKER_RST;
			end_marker_q   <= dfxc_pkg::END_MARKER_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				dfxc_pkg::REG_START_MARKER: start_marker_q <= cfg_data;
				dfxc_pkg::REG_END_MARKER:   end_marker_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = !out_valid || out_ready;
	assign step     = in_valid && in_ready;

	dfxc_frame_fsm u_fsm (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.byte_in      (byte_in),
		.start_marker (start_marker_q),
		.end_marker   (end_marker_q),
		.res_valid    (res_valid),
		.res          (res)
	);

	dfxc_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && res_valid),
		.res       (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign kind          = res_q.kind;
	assign data_byte     = res_q.data_byte;
	assign frame_serial  = res_q.frame_serial;
	assign frame_command = res_q.frame_command;
	assign command_class = res_q.command_class;
	assign body_length   = res_q.body_length;
	assign last          = res_q.last;

	`DFXC_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid, "result beat dropped")
	`DFXC_ASSERT_SAME(a_last_kind, out_valid, last == (kind != dfxc_pkg::KIND_BODY), "last/kind mismatch")
	`DFXC_ASSERT_SAME(a_verdict_zero, out_valid && last, data_byte == 8'h00, "verdict carries data")
	`DFXC_ASSERT_SAME(a_class_range, out_valid, command_class <= 3'd4, "command class out of range")

endmodule

// ===== rtl/dfxc_frame_fsm.sv =====
// ---------------------------------------------------------------------------
// Frame phase tracker
// Steps the frame phase on each accepted byte and forms its result.
// ---------------------------------------------------------------------------
module dfxc_frame_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_in,
	input  logic [7:0]        start_marker,
	input  logic [7:0]        end_marker,
	output logic              res_valid,
	output dfxc_pkg::result_t res
);

	typedef enum logic [6:0] {
		PH_HUNT    = 7'b0000001,
		PH_SERIAL  = 7'b0000010,
		PH_COMMAND = 7'b0000100,
		PH_LENGTH  = 7'b0001000,
		PH_BODY    = 7'b0010000,
		PH_CHECK   = 7'b0100000,
		PH_END     = 7'b1000000
	} phase_t;

	localparam logic [2:0] CLS_GENERAL     = 3'd0;
	localparam logic [2:0] CLS_QUERY       = 3'd1;
	localparam logic [2:0] CLS_REPORT      = 3'd2;
	localparam logic [2:0] CLS_PASSTHROUGH = 3'd3;
	localparam logic [2:0] CLS_OTHER       = 3'd4;

	function automatic logic [2:0] classify(input logic [7:0] cmd);
		logic [2:0] cls;
		priority if (cmd == 8'h80 || cmd == 8'h00) cls = CLS_GENERAL;
		else if (cmd == 8'h81) cls = CLS_QUERY;
		else if (cmd == 8'h01) cls = CLS_REPORT;
		else if (cmd == 8'h09 || cmd == 8'h89) cls = CLS_PASSTHROUGH;
		else cls = CLS_OTHER;
		return cls;
	endfunction

	phase_t     phase_q, phase_d;
	logic [7:0] serial_q, serial_d;
	logic [7:0] command_q, command_d;
	logic [2:0] class_q, class_d;
	logic [7:0] length_q, length_d;
	logic [7:0] remaining_q, remaining_d;
	logic [7:0] xor_q, xor_d;
	logic [7:0] check_q, check_d;

	always_comb begin
		phase_d     = phase_q;
		serial_d    = serial_q;
		command_d   = command_q;
		class_d     = class_q;
		length_d    = length_q;
		remaining_d = remaining_q;
		xor_d       = xor_q;
		check_d     = check_q;
		res_valid   = 1'b0;
		res.kind          = dfxc_pkg::KIND_BODY;
		res.data_byte     = 8'h00;
		res.frame_serial  = serial_q;
		res.frame_command = command_q;
		res.command_class = class_q;
		res.body_length   = length_q;
		res.last          = 1'b0;
		unique case (phase_q)
			PH_SERIAL: begin
				serial_d = byte_in;
				xor_d    = byte_in;
				phase_d  = PH_COMMAND;
			end
			PH_COMMAND: begin
				command_d = byte_in;
				class_d   = classify(byte_in);
				xor_d     = xor_q ^ byte_in;
				phase_d   = PH_LENGTH;
			end
			PH_LENGTH: begin
				length_d    = byte_in;
				remaining_d = byte_in;
				xor_d       = xor_q ^ byte_in;
				phase_d     = (byte_in == 8'h00) ? PH_CHECK : PH_BODY;
			end
			PH_BODY: begin
				xor_d         = xor_q ^ byte_in;
				remaining_d   = remaining_q - 8'd1;
				phase_d       = (remaining_q == 8'd1) ? PH_CHECK : PH_BODY;
				res_valid     = 1'b1;
				res.data_byte = byte_in;
			end
			PH_CHECK: begin
				check_d = byte_in;
				phase_d = PH_END;
			end
			PH_END: begin
				phase_d   = PH_HUNT;
				res_valid = 1'b1;
				res.last  = 1'b1;
				priority if (byte_in != end_marker) res.kind = dfxc_pkg::KIND_BAD_END;
				else if (xor_q != check_q) res.kind = dfxc_pkg::KIND_BAD_CHECK;
				else res.kind = dfxc_pkg::KIND_ACCEPTED;
			end
			default: begin
				phase_d = (byte_in == start_marker) ? PH_SERIAL : PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
		end else if (step) begin
			phase_q <= phase_d;
		end
	end

	// hold frame fields; every one is written before it is read
	always_ff @(posedge clk) begin
		if (step) begin
			serial_q    <= serial_d;
			command_q   <= command_d;
			class_q     <= class_d;
			length_q    <= length_d;
			remaining_q <= remaining_d;
			xor_q       <= xor_d;
			check_q     <= check_d;
		end
	end

endmodule

// ===== rtl/dfxc_out_reg.sv =====
// ---------------------------------------------------------------------------
// Result output register
// Holds one result beat until the consumer takes it.
// ---------------------------------------------------------------------------
module dfxc_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  dfxc_pkg::result_t res,
	input  logic              out_ready,
	output logic              out_valid,
	output dfxc_pkg::result_t res_q
);

	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;

endmodule
